@@ hw/rtl/brf_pkg.sv @@
// Package for the circular byte FIFO: word layouts, command kinds, status codes.
// Shared by brf_front, brf_queue, brf_back and byte_ring_fifo_core; no dependencies.
package brf_pkg;

  localparam int DEPTH_DEFAULT   = 1024;
  localparam int MAX_RUN_DEFAULT = 64;

  localparam int LEN_W    = 7;
  localparam int REPORT_W = 10;
  localparam int STATUS_W = 2;

  // The command queue depth must stay a power of two: its pointers wrap naturally.
  localparam int Q_DEPTH = 2;

  localparam logic [LEN_W-1:0] BATCH_SAT = 7'd127;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    K_PUSH,
    K_POP,
    K_PEEK,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data_byte;
    logic             batch_end;
    logic [LEN_W-1:0] req_len;
  } in_word_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                run_last;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    count;
    logic [REPORT_W-1:0] used;
    logic [REPORT_W-1:0] free_space;
  } out_word_t;

  // Decoded command as it travels from the front end to the back end.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic             batch_end;
    logic [LEN_W-1:0] req_len;
  } cmd_t;

endpackage

@@ hw/rtl/byte_ring_fifo_core.sv @@
// Top level of the circular byte FIFO that keeps one slot empty.
// Depends on brf_pkg, brf_front, brf_queue and brf_back.
//
// Usage: drive a command word on cmd and raise start; the word is taken at a
// rising edge where start is high and busy is low. Busy rises only when the
// two-entry command queue between the front end and the back end is full.
// Each result word appears on result for exactly one cycle with strobe high;
// the receiver cannot stall, so results are never held back.
// Path: a taken word is registered in the command queue and waits there until
// the back end is idle. A push, a clear or a read with nothing to return has
// its result registered as the back end takes the word; a run first registers
// its setup, and its first byte then comes from the registered store read.
// Throughput: push, clear and zero-length or empty reads are each done by the
// back end in its idle state, so pushes stream at one word per cycle while no
// read run holds the back end. A pop or peek run holds the back end for a setup
// step, then one byte per cycle through the single read port of the byte store;
// words keep queuing meanwhile until the queue fills.
// Reset (rst, synchronous) empties the ring, zeroes both pointers and the open
// batch count, and flushes the command queue. The byte store itself is not
// cleared: only bytes that were pushed can ever be read back.
module byte_ring_fifo_core #(
  parameter int DEPTH   = brf_pkg::DEPTH_DEFAULT,
  parameter int MAX_RUN = brf_pkg::MAX_RUN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  brf_pkg::in_word_t  cmd,
  output logic               strobe,
  output brf_pkg::out_word_t result
);
  import brf_pkg::*;

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_head;

  // The front end only decodes and clamps; it never waits on the back end
  // except through the queue's full flag.
  assign busy = q_full;

  brf_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .start (start),
    .q_full(q_full),
    .cmd   (cmd),
    .q_push(q_push),
    .q_cmd (q_in)
  );

  brf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_in),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  // The back end owns all ring state, so commands take effect strictly in
  // the order they were accepted.
  brf_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

@@ hw/rtl/brf_front.sv @@
// Front end of the circular byte FIFO: accepts command words and classifies them.
// Depends on brf_pkg.
module brf_front #(
  parameter int MAX_RUN = brf_pkg::MAX_RUN_DEFAULT
) (
  input  logic             start,
  input  logic             q_full,
  input  brf_pkg::in_word_t cmd,
  output logic             q_push,
  output brf_pkg::cmd_t    q_cmd
);
  import brf_pkg::*;

  localparam logic [LEN_W-1:0] RUN_MAX = LEN_W'(MAX_RUN);

  assign q_push = start && !q_full;

  always_comb begin
    q_cmd.data_byte = cmd.data_byte;
    q_cmd.batch_end = cmd.batch_end;
    // Requests above the run limit are cut down to the limit.
    q_cmd.req_len = (cmd.req_len > RUN_MAX) ? RUN_MAX : cmd.req_len;
    case (cmd.op)
      OP_PUSH:  q_cmd.kind = K_PUSH;
      OP_POP:   q_cmd.kind = K_POP;
      OP_PEEK:  q_cmd.kind = K_PEEK;
      OP_CLEAR: q_cmd.kind = K_CLEAR;
      default:  q_cmd.kind = K_CLEAR;
    endcase
  end

endmodule

@@ hw/rtl/brf_queue.sv @@
// Short command queue between the front and back ends of the circular byte FIFO.
// Depends on brf_pkg.
module brf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output brf_pkg::cmd_t head
);
  import brf_pkg::*;

  localparam int Q_AW = $clog2(Q_DEPTH);

  cmd_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_idx;
  logic [Q_AW-1:0] rd_idx;
  logic [Q_AW:0]   fill;

  assign full  = (fill == (Q_AW + 1)'(Q_DEPTH));
  assign valid = (fill != '0);
  assign head  = entries[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/brf_back.sv @@
// Back end of the circular byte FIFO: byte store, pointers, batch count and result words.
// Depends on brf_pkg.
module brf_back #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  brf_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               strobe,
  output brf_pkg::out_word_t result
);
  import brf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int SUM_W = PTR_W + 1;
  localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t              state;
  logic [7:0]          mem [DEPTH];
  logic [7:0]          rd_data;
  logic [PTR_W-1:0]    read_ptr;
  logic [PTR_W-1:0]    write_ptr;
  logic [PTR_W-1:0]    used;
  logic [LEN_W-1:0]    batch_accepted;
  logic [PTR_W-1:0]    run_addr;
  logic [LEN_W-1:0]    run_left;
  logic [LEN_W-1:0]    run_total;
  logic [REPORT_W-1:0] run_used;
  logic [REPORT_W-1:0] run_free;

  logic                res_valid;
  logic                res_read;
  logic                res_last;
  logic [STATUS_W-1:0] res_status;
  logic [LEN_W-1:0]    res_count;
  logic [REPORT_W-1:0] res_used;
  logic [REPORT_W-1:0] res_free;

  logic                full;
  logic                mem_we;
  logic [PTR_W-1:0]    write_ptr_next;
  logic [PTR_W-1:0]    run_addr_next;
  logic [LEN_W-1:0]    run_n;
  logic [PTR_W-1:0]    run_n_ptr;
  logic [SUM_W-1:0]    adv_sum;
  logic [PTR_W-1:0]    read_ptr_next;
  logic [PTR_W-1:0]    used_push;
  logic [PTR_W-1:0]    used_pop;
  logic [LEN_W-1:0]    batch_next;

  function automatic logic [REPORT_W-1:0] rep_used(input logic [PTR_W-1:0] u);
    return REPORT_W'(u);
  endfunction

  function automatic logic [REPORT_W-1:0] rep_free(input logic [PTR_W-1:0] u);
    return REPORT_W'(LAST_SLOT - u);
  endfunction

  assign q_pop = q_valid && (state == S_IDLE);
  assign full  = (used == LAST_SLOT);

  always_comb begin
    mem_we         = q_pop && (q_head.kind == K_PUSH) && !full;
    write_ptr_next = (write_ptr == LAST_SLOT) ? '0 : write_ptr + 1'b1;
    run_addr_next  = (run_addr == LAST_SLOT) ? '0 : run_addr + 1'b1;
    used_push      = used + 1'b1;
    // A run returns no more bytes than the ring holds.
    if (CMP_W'(used) < CMP_W'(q_head.req_len)) begin
      run_n = LEN_W'(used);
    end else begin
      run_n = q_head.req_len;
    end
    run_n_ptr = PTR_W'(run_n);
    adv_sum   = SUM_W'(read_ptr) + SUM_W'(run_n_ptr);
    if (adv_sum >= DEPTH_S) begin
      read_ptr_next = PTR_W'(adv_sum - DEPTH_S);
    end else begin
      read_ptr_next = PTR_W'(adv_sum);
    end
    used_pop = used - run_n_ptr;
    if (!full && (batch_accepted != BATCH_SAT)) begin
      batch_next = batch_accepted + 1'b1;
    end else begin
      batch_next = batch_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_ptr] <= q_head.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[run_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      read_ptr       <= '0;
      write_ptr      <= '0;
      used           <= '0;
      batch_accepted <= '0;
      res_valid      <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            res_valid  <= 1'b1;
            res_read   <= 1'b0;
            res_last   <= 1'b1;
            res_status <= ST_OK;
            res_count  <= '0;
            res_used   <= rep_used(used);
            res_free   <= rep_free(used);
            case (q_head.kind)
              K_PUSH: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  write_ptr <= write_ptr_next;
                  used      <= used_push;
                  res_used  <= rep_used(used_push);
                  res_free  <= rep_free(used_push);
                end
                if (q_head.batch_end) begin
                  res_count      <= batch_next;
                  batch_accepted <= '0;
                end else begin
                  batch_accepted <= batch_next;
                end
              end
              K_CLEAR: begin
                read_ptr  <= '0;
                write_ptr <= '0;
                used      <= '0;
                res_used  <= rep_used('0);
                res_free  <= rep_free('0);
              end
              K_POP, K_PEEK: begin
                if (run_n == '0) begin
                  res_status <= (q_head.req_len != '0) ? ST_EMPTY : ST_OK;
                end else begin
                  res_valid <= 1'b0;
                  state     <= S_RUN;
                  run_addr  <= read_ptr;
                  run_left  <= run_n;
                  run_total <= run_n;
                  if (q_head.kind == K_POP) begin
                    read_ptr <= read_ptr_next;
                    used     <= used_pop;
                    run_used <= rep_used(used_pop);
                    run_free <= rep_free(used_pop);
                  end else begin
                    run_used <= rep_used(used);
                    run_free <= rep_free(used);
                  end
                end
              end
              default: begin
                res_valid <= 1'b0;
              end
            endcase
          end
        end
        S_RUN: begin
          res_valid  <= 1'b1;
          res_read   <= 1'b1;
          res_status <= ST_OK;
          res_used   <= run_used;
          res_free   <= run_free;
          res_last   <= (run_left == LEN_W'(1));
          res_count  <= (run_left == LEN_W'(1)) ? run_total : '0;
          run_addr   <= run_addr_next;
          run_left   <= run_left - 1'b1;
          if (run_left == LEN_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe = res_valid;

  always_comb begin
    result.out_byte   = res_read ? rd_data : 8'd0;
    result.run_last   = res_last;
    result.status     = res_status;
    result.count      = res_count;
    result.used       = res_used;
    result.free_space = res_free;
  end

endmodule

@@ verif/byte_ring_fifo_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for byte_ring_fifo_core: watches the command and result channels,
// keeps its own copy of the ring and compares each result word in order.
// Depends on brf_pkg only.
module byte_ring_fifo_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  brf_pkg::in_word_t  cmd,
  input  logic               strobe,
  input  brf_pkg::out_word_t result,
  output int                 mismatches,
  output int                 pending
);
  import brf_pkg::*;

  localparam int RING = DEPTH_DEFAULT;
  localparam int RUN  = MAX_RUN_DEFAULT;

  logic [7:0]       ring [RING];
  int               rd_ptr;
  int               wr_ptr;
  logic [LEN_W-1:0] batch_acc;
  out_word_t        fifo_replies [$];
  int               mism_cnt;
  int               words_seen;

  function automatic int fill_level();
    return (wr_ptr + RING - rd_ptr) % RING;
  endfunction

  // Occupancy is reported after the whole command has taken effect.
  function automatic out_word_t make_reply(logic [7:0] b, logic last,
                                           logic [STATUS_W-1:0] st,
                                           logic [LEN_W-1:0] cnt);
    out_word_t r;
    r.out_byte   = b;
    r.run_last   = last;
    r.status     = st;
    r.count      = cnt;
    r.used       = REPORT_W'(fill_level());
    r.free_space = REPORT_W'(RING - 1 - fill_level());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mism_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d field %s: got %0d, expected %0d",
                                words_seen, name, got, want));
    end
  endtask

  // Applies one accepted command to the ring copy and queues its result words.
  task automatic fifo_apply(input in_word_t w);
    int                  n;
    int                  first;
    logic [STATUS_W-1:0] st;
    logic [LEN_W-1:0]    cnt;
    case (w.op)
      OP_PUSH: begin
        st  = ST_OK;
        cnt = '0;
        if (fill_level() < RING - 1) begin
          ring[wr_ptr] = w.data_byte;
          wr_ptr       = (wr_ptr + 1) % RING;
          if (batch_acc != BATCH_SAT) begin
            batch_acc = batch_acc + 1'b1;
          end
        end else begin
          st = ST_FULL;
        end
        if (w.batch_end) begin
          cnt       = batch_acc;
          batch_acc = '0;
        end
        fifo_replies.push_back(make_reply(8'h00, 1'b1, st, cnt));
      end
      OP_CLEAR: begin
        // The open batch count survives a clear.
        rd_ptr = 0;
        wr_ptr = 0;
        fifo_replies.push_back(make_reply(8'h00, 1'b1, ST_OK, '0));
      end
      OP_POP, OP_PEEK: begin
        n = (w.req_len > RUN) ? RUN : int'(w.req_len);
        if (n > fill_level()) begin
          n = fill_level();
        end
        if (n == 0) begin
          st = (w.req_len != '0) ? ST_EMPTY : ST_OK;
          fifo_replies.push_back(make_reply(8'h00, 1'b1, st, '0));
        end else begin
          first = rd_ptr;
          if (w.op == OP_POP) begin
            rd_ptr = (rd_ptr + n) % RING;
          end
          for (int i = 0; i < n; i++) begin
            fifo_replies.push_back(make_reply(ring[(first + i) % RING], i == n - 1,
                                              ST_OK, (i == n - 1) ? LEN_W'(n) : '0));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      rd_ptr    = 0;
      wr_ptr    = 0;
      batch_acc = '0;
      fifo_replies.delete();
    end else begin
      // Results at this edge always belong to earlier commands, so they are
      // matched before the command taken at this edge is applied.
      if (strobe) begin
        if (fifo_replies.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected: %h",
                                    words_seen, result));
        end else begin
          want = fifo_replies.pop_front();
          check_field("out_byte", result.out_byte, want.out_byte);
          check_field("run_last", result.run_last, want.run_last);
          check_field("status", result.status, want.status);
          check_field("count", result.count, want.count);
          check_field("used", result.used, want.used);
          check_field("free_space", result.free_space, want.free_space);
        end
        words_seen++;
      end
      if (start && !busy) begin
        fifo_apply(cmd);
      end
    end
    pending    <= fifo_replies.size();
    mismatches <= mism_cnt;
  end

endmodule

@@ verif/tb_byte_ring_fifo_core.sv @@
`timescale 1ns / 1ps
// Testbench top for byte_ring_fifo_core: makes the command stimulus and gives the verdict.
// Depends on brf_pkg, byte_ring_fifo_core and byte_ring_fifo_checker.
module tb_byte_ring_fifo_core;
  import brf_pkg::*;

  // The slowest correct run ends well within this limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 24;
  // The last random words go in back to back, with no idle cycles.
  localparam int QUIET_TAIL   = 8;
  // A little more than one full run, so reads hit the run limit.
  localparam int FILL_BYTES   = 66;
  localparam int RUN          = MAX_RUN_DEFAULT;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_word_t  cmd   = '0;
  logic      busy;
  logic      strobe;
  out_word_t result;
  int        mismatches;
  int        pending;
  int        cycles  = 0;
  bit        gaps_on = 1'b1;
  int        sent    = 0;
  int        rand_base;
  int        pick;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_ring_fifo_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  byte_ring_fifo_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .strobe     (strobe),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** byte_ring_fifo_core: FAILED **");
      $finish;
    end
  end

  // Sends one command word. An optional idle burst may come first; then start
  // stays high until the word is taken at an edge where busy is low. Busy is
  // read right after the edge, so it is the value that the block itself used
  // at that edge.
  task automatic issue(input logic [1:0] op, input logic [7:0] data,
                       input logic last, input logic [LEN_W-1:0] len);
    in_word_t w;
    w.op        = op;
    w.data_byte = data;
    w.batch_end = last;
    w.req_len   = len;
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd   <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // A well-formed push batch: random bytes, with the end mark on the last word
  // only. The request length is ignored on a push, so it is random as well.
  task automatic push_batch(input int n);
    for (int i = 0; i < n; i++) begin
      issue(OP_PUSH, 8'($urandom), i == n - 1, LEN_W'($urandom_range(127)));
    end
  endtask

  // Read lengths: mostly within one run, sometimes oversized up to the field's top.
  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(3) == 0) begin
      return LEN_W'($urandom_range(127));
    end
    return LEN_W'($urandom_range(RUN));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reads on the empty ring first: a nonzero request reports
    // nothing to read, while a zero request is a plain ok.
    issue(OP_POP, 8'h00, 1'b0, 7'd5);
    issue(OP_PEEK, 8'h00, 1'b0, 7'd1);
    issue(OP_POP, 8'h00, 1'b0, 7'd0);
    // A batch of one byte, with extreme data and request values.
    issue(OP_PUSH, 8'h00, 1'b1, 7'd0);
    // An open batch survives a clear: the final count takes in the two bytes
    // pushed before the clear, although the ring then holds only one byte.
    issue(OP_PUSH, 8'hFF, 1'b0, 7'h7F);
    issue(OP_PUSH, 8'hA5, 1'b0, 7'd0);
    issue(OP_CLEAR, 8'h00, 1'b0, 7'd0);
    issue(OP_PUSH, 8'h5A, 1'b1, 7'd0);
    issue(OP_PUSH, 8'h01, 1'b0, 7'd64);
    issue(OP_PUSH, 8'h80, 1'b0, 7'd0);
    issue(OP_PUSH, 8'h7E, 1'b1, 7'd0);
    // A zero request on a non-empty ring, a short peek, then an oversized pop
    // that is cut down to what the ring holds.
    issue(OP_PEEK, 8'h00, 1'b0, 7'd0);
    issue(OP_PEEK, 8'h00, 1'b0, 7'd2);
    issue(OP_POP, 8'h00, 1'b0, 7'd127);
    issue(OP_POP, 8'h00, 1'b1, 7'd3);

    // One batch holds more bytes than a single run can return.
    push_batch(FILL_BYTES);
    // Full-length and oversized reads, then pops of one full run each: a full
    // run, the short remainder, and one more read that finds nothing.
    issue(OP_PEEK, 8'h00, 1'b0, 7'd127);
    issue(OP_PEEK, 8'h00, 1'b0, 7'd65);
    issue(OP_PEEK, 8'h00, 1'b0, 7'd64);
    repeat (3) issue(OP_POP, 8'h00, 1'b0, 7'd64);

    // Random part. The ring is empty again, with both pointers part way round.
    // Most words come as push batches and reads; the rest is clears and noise
    // such as stray end marks and zero requests.
    rand_base = sent;
    while (sent < rand_base + RANDOM_WORDS) begin
      gaps_on = (sent < rand_base + RANDOM_WORDS - QUIET_TAIL);
      pick    = $urandom_range(99);
      if (pick < 45) begin
        push_batch($urandom_range(6, 1));
      end else if (pick < 62) begin
        issue(OP_POP, 8'($urandom), 1'($urandom), rand_len());
      end else if (pick < 80) begin
        issue(OP_PEEK, 8'($urandom), 1'($urandom), rand_len());
      end else if (pick < 85) begin
        issue(OP_CLEAR, 8'($urandom), 1'($urandom), LEN_W'($urandom_range(127)));
      end else if (pick < 95) begin
        issue(OP_PUSH, 8'($urandom), 1'($urandom), LEN_W'($urandom_range(127)));
      end else begin
        issue(OP_POP, 8'($urandom), 1'($urandom), 7'd0);
      end
    end
    start <= 1'b0;

    // Let every expected word come back, then give stray words time to show.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("** byte_ring_fifo_core: PASSED **");
    end else begin
      $display("** byte_ring_fifo_core: FAILED **");
    end
    $finish;
  end

endmodule
